### rtl/core/urac_pkg.sv
`default_nettype none

package urac_pkg;

  // echo counter width; the distance accumulator carries 9 more bits (443 < 512)
  localparam int EchoCountBits = 16;
  localparam int AccBits       = EchoCountBits + 9;
  localparam int DistBits      = 17;
  localparam int CfgIndexBits  = 2;
  localparam int CfgDataBits   = 20;

  localparam logic [EchoCountBits-1:0] EchoCountMax = '1;
  localparam logic [DistBits-1:0]      DistMax      = '1;
  // 343 m/s * 1e-6 s * 39.3701 in/m / 2 (round trip) * 256 ~ 1.7285, rounded to 443/256
  localparam logic [8:0]               DistPerTick  = 9'd443;
  localparam logic [19:0]              DebounceMax  = 20'hFFFFF;

  localparam logic [6:0]  WindowReset   = 7'd20;
  localparam logic [9:0]  TriggerReset  = 10'd10;
  localparam logic [19:0] DebounceReset = 20'd100000;

  localparam logic [CfgIndexBits-1:0] REG_WINDOW   = 2'd0;
  localparam logic [CfgIndexBits-1:0] REG_TRIGGER  = 2'd1;
  localparam logic [CfgIndexBits-1:0] REG_DEBOUNCE = 2'd2;

  typedef enum logic [1:0] {
    PHASE_TRIG  = 2'd0,
    PHASE_WAIT  = 2'd1,
    PHASE_COUNT = 2'd2
  } range_phase_t;

  typedef enum logic [1:0] {
    BTN_RELEASED = 2'd0,
    BTN_DEBOUNCE = 2'd1,
    BTN_HELD     = 2'd2
  } button_phase_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ARMED = 2'd1,
    MODE_ALARM = 2'd2
  } mode_t;

  typedef struct packed {
    logic                trigger_out;
    logic                buzzer_on;
    logic                red_led;
    logic                green_led;
    logic [1:0]          mode;
    logic [DistBits-1:0] distance;
    logic                measure_done;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/urac_if.sv
`default_nettype none

interface urac_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [urac_pkg::CfgIndexBits-1:0] reg_index;
  logic [urac_pkg::CfgDataBits-1:0]  reg_data;
  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

interface urac_in_if;
  logic valid;
  logic ready;
  logic echo_level;
  logic button_level;
  modport source (output valid, echo_level, button_level, input ready);
  modport sink (input valid, echo_level, button_level, output ready);
endinterface

interface urac_out_if;
  logic                          valid;
  logic                          ready;
  logic                          trigger_out;
  logic                          buzzer_on;
  logic                          red_led;
  logic                          green_led;
  logic [1:0]                    mode;
  logic [urac_pkg::DistBits-1:0] distance;
  logic                          measure_done;
  modport source (output valid, trigger_out, buzzer_on, red_led, green_led, mode, distance,
                  measure_done, input ready);
  modport sink (input valid, trigger_out, buzzer_on, red_led, green_led, mode, distance,
                measure_done, output ready);
endinterface

`default_nettype wire

### rtl/core/ultrasonic_range_alarm_controller_unit.sv
// channel  | dir | payload                                      | word
// ---------+-----+----------------------------------------------+------------------------
// cfg      | in  | reg_index[1:0], reg_data[19:0]               | one register write
// sample   | in  | echo_level, button_level                     | one 1 MHz tick of pins
// result   | out | trigger_out, buzzer_on, red_led, green_led,  | one per sample word
//          |     | mode[1:0], distance[16:0], measure_done      |
//
// One sample word per cycle while sample.ready is high; its result word is registered.
// All tick work (sequencer, debounce, distance scale, window compare) is one
// registered pass; the window compare's three multiplies set the cycle time.
// A two-entry output stage (result register plus skid) keeps sample.ready high
// while one result waits; ready drops only when both entries are full.
// rst (synchronous) restores register defaults and empties the output stage; cfg is always ready.
`default_nettype none

module ultrasonic_range_alarm_controller_unit (
  input  logic       clk,
  input  logic       rst,
  urac_cfg_if.sink   cfg,
  urac_in_if.sink    sample,
  urac_out_if.source result
);

  logic [6:0]  window_percent;
  logic [9:0]  trigger_ticks;
  logic [19:0] debounce_ticks;

  urac_pkg::range_phase_t  range_phase, range_phase_next;
  logic [9:0]              phase_ticks, phase_ticks_next, phase_ticks_inc;
  logic [urac_pkg::EchoCountBits-1:0] echo_ticks, echo_ticks_next;
  logic [urac_pkg::AccBits-1:0]       echo_acc, echo_acc_next;
  logic [urac_pkg::DistBits-1:0]      last_distance, last_distance_next;
  logic [urac_pkg::DistBits-1:0]      armed_distance, armed_distance_next;
  logic [urac_pkg::DistBits-1:0]      meas_distance;
  logic [31:0]                        acc_scaled;
  urac_pkg::mode_t         alarm_mode, alarm_mode_next;
  urac_pkg::button_phase_t button_phase, button_phase_next;
  logic [19:0]             debounce_count, debounce_count_next, debounce_inc;
  logic                    press_latched, press_latched_next, press_now;
  logic                    meas_done, trig_now;
  logic [9:0]              trig_len;
  logic                    pressed, need_one;
  logic [19:0]             need;

  logic [6:0]  win_clamped;
  logic [24:0] dist_x100, lo_bound, hi_bound;
  logic        in_window;

  urac_pkg::result_t res_word, out_word, skid_word;
  logic              out_valid, skid_valid;
  logic              take_in, take_out;

  // ---------------- configuration ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_percent <= urac_pkg::WindowReset;
      trigger_ticks  <= urac_pkg::TriggerReset;
      debounce_ticks <= urac_pkg::DebounceReset;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        urac_pkg::REG_WINDOW:   window_percent <= cfg.reg_data[6:0];
        urac_pkg::REG_TRIGGER:  trigger_ticks  <= cfg.reg_data[9:0];
        urac_pkg::REG_DEBOUNCE: debounce_ticks <= cfg.reg_data;
        default: ;
      endcase
    end
  end

  assign take_in  = sample.valid && sample.ready;
  assign take_out = out_valid && result.ready;

  // ---------------- ranging sequencer ----------------
  assign trig_len        = (trigger_ticks == 10'd0) ? 10'd1 : trigger_ticks;
  assign phase_ticks_inc = phase_ticks + 10'd1;

  always_comb begin
    range_phase_next = range_phase;
    phase_ticks_next = phase_ticks;
    echo_ticks_next  = echo_ticks;
    echo_acc_next    = echo_acc;
    meas_done        = 1'b0;
    unique case (range_phase)
      urac_pkg::PHASE_WAIT: begin
        if (sample.echo_level) begin
          range_phase_next = urac_pkg::PHASE_COUNT;
          echo_ticks_next  = urac_pkg::EchoCountBits'(1);
          echo_acc_next    = urac_pkg::AccBits'(urac_pkg::DistPerTick);
        end
      end
      urac_pkg::PHASE_COUNT: begin
        if (sample.echo_level) begin
          if (echo_ticks != urac_pkg::EchoCountMax) begin
            echo_ticks_next = echo_ticks + urac_pkg::EchoCountBits'(1);
            echo_acc_next   = echo_acc + urac_pkg::AccBits'(urac_pkg::DistPerTick);
          end
        end else begin
          range_phase_next = urac_pkg::PHASE_TRIG;
          phase_ticks_next = 10'd0;
          meas_done        = 1'b1;
        end
      end
      default: begin
        // unused code runs as the trigger phase; counter wrap also ends it
        range_phase_next = urac_pkg::PHASE_TRIG;
        phase_ticks_next = phase_ticks_inc;
        if (phase_ticks_inc == 10'd0 || phase_ticks_inc >= trig_len) begin
          phase_ticks_next = 10'd0;
          range_phase_next = urac_pkg::PHASE_WAIT;
        end
      end
    endcase
  end

  always_comb begin
    trig_now = (range_phase != urac_pkg::PHASE_WAIT) && (range_phase != urac_pkg::PHASE_COUNT);
  end

  // acc holds echo_ticks*443, so the distance is a plain shift
  assign acc_scaled    = 32'(echo_acc >> 8);
  assign meas_distance = (acc_scaled > 32'(urac_pkg::DistMax)) ? urac_pkg::DistMax
                                                               : acc_scaled[16:0];
  assign last_distance_next = meas_done ? meas_distance : last_distance;

  // ---------------- button qualifier ----------------
  assign pressed      = !sample.button_level;
  assign need_one     = (debounce_ticks <= 20'd1);
  assign need         = (debounce_ticks == 20'd0) ? 20'd1 : debounce_ticks;
  assign debounce_inc = (debounce_count != urac_pkg::DebounceMax) ? debounce_count + 20'd1
                                                                  : debounce_count;

  always_comb begin
    button_phase_next   = button_phase;
    debounce_count_next = debounce_count;
    press_now           = press_latched;
    unique case (button_phase)
      urac_pkg::BTN_DEBOUNCE: begin
        if (!pressed) begin
          button_phase_next   = urac_pkg::BTN_RELEASED;
          debounce_count_next = 20'd0;
        end else begin
          debounce_count_next = debounce_inc;
          if (debounce_inc >= need) button_phase_next = urac_pkg::BTN_HELD;
        end
      end
      urac_pkg::BTN_HELD: begin
        // press counts on release after a qualified hold
        if (!pressed) begin
          press_now           = 1'b1;
          button_phase_next   = urac_pkg::BTN_RELEASED;
          debounce_count_next = 20'd0;
        end
      end
      default: begin
        button_phase_next = urac_pkg::BTN_RELEASED;
        if (pressed) begin
          debounce_count_next = 20'd1;
          button_phase_next   = need_one ? urac_pkg::BTN_HELD : urac_pkg::BTN_DEBOUNCE;
        end
      end
    endcase
  end

  // ---------------- window compare ----------------
  assign win_clamped = (window_percent > 7'd100) ? 7'd100 : window_percent;
  assign dist_x100   = 25'(meas_distance) * 25'd100;
  assign lo_bound    = 25'(armed_distance) * 25'(7'd100 - win_clamped);
  assign hi_bound    = 25'(armed_distance) * (25'd100 + 25'(win_clamped));
  assign in_window   = (dist_x100 > lo_bound) && (dist_x100 < hi_bound);

  // ---------------- mode machine ----------------
  always_comb begin
    alarm_mode_next     = alarm_mode;
    armed_distance_next = armed_distance;
    press_latched_next  = press_now;
    if (meas_done) begin
      press_latched_next = 1'b0;
      unique case (alarm_mode)
        urac_pkg::MODE_ARMED: begin
          if (!in_window) alarm_mode_next = urac_pkg::MODE_ALARM;
        end
        urac_pkg::MODE_ALARM: begin
          if (press_now) begin
            armed_distance_next = meas_distance;
            alarm_mode_next     = urac_pkg::MODE_ARMED;
          end
        end
        default: begin
          alarm_mode_next = urac_pkg::MODE_IDLE;
          if (press_now) begin
            armed_distance_next = meas_distance;
            alarm_mode_next     = urac_pkg::MODE_ARMED;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_word.trigger_out  = trig_now;
    res_word.buzzer_on    = (alarm_mode_next == urac_pkg::MODE_ALARM);
    res_word.red_led      = (alarm_mode_next == urac_pkg::MODE_ALARM);
    res_word.green_led    = (alarm_mode_next != urac_pkg::MODE_ALARM);
    res_word.mode         = alarm_mode_next;
    res_word.distance     = last_distance_next;
    res_word.measure_done = meas_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_phase    <= urac_pkg::PHASE_TRIG;
      phase_ticks    <= 10'd0;
      echo_ticks     <= '0;
      echo_acc       <= '0;
      last_distance  <= '0;
      armed_distance <= '0;
      alarm_mode     <= urac_pkg::MODE_IDLE;
      button_phase   <= urac_pkg::BTN_RELEASED;
      debounce_count <= 20'd0;
      press_latched  <= 1'b0;
    end else if (take_in) begin
      range_phase    <= range_phase_next;
      phase_ticks    <= phase_ticks_next;
      echo_ticks     <= echo_ticks_next;
      echo_acc       <= echo_acc_next;
      last_distance  <= last_distance_next;
      armed_distance <= armed_distance_next;
      alarm_mode     <= alarm_mode_next;
      button_phase   <= button_phase_next;
      debounce_count <= debounce_count_next;
      press_latched  <= press_latched_next;
    end
  end

  // ---------------- output register + skid ----------------
  assign sample.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_out) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take_in;
      end
    end else if (take_in) begin
      if (out_valid) skid_valid <= 1'b1;
      else out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      if (skid_valid) out_word <= skid_word;
      else if (take_in) out_word <= res_word;
    end else if (take_in) begin
      if (out_valid) skid_word <= res_word;
      else out_word <= res_word;
    end
  end

  assign result.valid        = out_valid;
  assign result.trigger_out  = out_word.trigger_out;
  assign result.buzzer_on    = out_word.buzzer_on;
  assign result.red_led      = out_word.red_led;
  assign result.green_led    = out_word.green_led;
  assign result.mode         = out_word.mode;
  assign result.distance     = out_word.distance;
  assign result.measure_done = out_word.measure_done;

endmodule

`default_nettype wire

### rtl/core/urac_checker.sv
`default_nettype none

module urac_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic                          buzzer_on,
  input logic                          red_led,
  input logic                          green_led,
  input logic [1:0]                    mode,
  input logic [urac_pkg::DistBits-1:0] distance,
  input logic                          measure_done
);

  logic                          have_prev;
  logic [1:0]                    prev_mode;
  logic [urac_pkg::DistBits-1:0] prev_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (result_valid && result_ready) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && result_ready) begin
      prev_mode     <= mode;
      prev_distance <= distance;
    end
  end

  // output stage is empty and input open right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> sample_ready && !result_valid)
    else $error("output stage not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped while stalled");

  a_leds_follow_mode: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (buzzer_on == red_led) && (green_led != buzzer_on) &&
                     (buzzer_on == (mode == 2'(urac_pkg::MODE_ALARM))))
    else $error("buzzer/led outputs disagree with mode");

  // mode and distance only move on a measurement word
  a_step_only_on_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && have_prev && !measure_done |->
      (mode == prev_mode) && (distance == prev_distance))
    else $error("mode or distance changed without a measurement");

endmodule

bind ultrasonic_range_alarm_controller_unit urac_checker u_urac_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .buzzer_on    (result.buzzer_on),
  .red_led      (result.red_led),
  .green_led    (result.green_led),
  .mode         (result.mode),
  .distance     (result.distance),
  .measure_done (result.measure_done)
);

`default_nettype wire
